// ===== hw/rtl/ffra_pkg.sv =====
package ffra_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int PAGE_BYTES    = 4096;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int PAGE_W        = $clog2(PAGE_BYTES);
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
   localparam int STEP_W        = SLOT_W + 1;

   localparam logic [31:0] BASE_RESET = 32'h4000_0000;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   typedef struct packed {
      logic        action;
      logic [31:0] request_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] region_address;
      logic [7:0]  live_regions;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       start;
      logic [31:0]       span;
      logic [SLOT_W-1:0] link;
      logic              link_valid;
   } entry_type;

endpackage

// ===== hw/rtl/ffra_ram.sv =====
module ffra_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/first_fit_region_allocator.sv =====
// Busy stays high until each request's single result word is strobed on rsp_valid for one
// cycle; the receiver cannot stall it, so it must take the word then. An allocate scans the
// slot table one slot per cycle for the first free slot, then, if a region is held, walks the
// region list through the entry memory (separate read and write ports), one read per list
// step, and ends with up to two writes. A free walks the list the same way, through a wait
// state and a check state per step; a free while no region is held is answered from idle
// without raising busy. The base register may be written through csr_ whenever the block is
// idle; it is always ready.
module first_fit_region_allocator
   import ffra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_AHEAD, S_ASTEP, S_ANEXT, S_CHECK, S_AWLINK, S_FWAIT, S_FSTEP
   } state_type;

   state_type          state_ff;
   logic [31:0]        base_ff;
   logic [TABLE_ENTRIES-1:0] used_ff;
   logic [SLOT_W-1:0]  head_ff;
   logic               nonempty_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [32:0]        rounded_ff;
   logic [31:0]        addr_ff;
   logic [SLOT_W-1:0]  scan_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  p_ff;
   logic [SLOT_W-1:0]  prevp_ff;
   logic               has_prev_ff;
   logic [STEP_W-1:0]  steps_ff;
   entry_type          cur_ff;
   entry_type          prev_ff;
   logic [32:0]        cur_end_ff;
   logic [32:0]        start_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;

   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   entry_type          ram_wdata;
   logic [SLOT_W-1:0]  ram_raddr;
   entry_type          ram_rdata;

   logic [32:0]        round_sum;
   logic [32:0]        gap;
   logic               fits;
   logic [33:0]        end_sum;
   logic               overflow;
   logic               walk_done;
   logic               match;

   assign round_sum = {1'b0, req.request_bytes} + 33'(PAGE_BYTES - 1);
   assign gap       = {1'b0, ram_rdata.start} - cur_end_ff;
   assign fits      = ({1'b0, ram_rdata.start} >= cur_end_ff) && (gap >= rounded_ff);
   assign end_sum   = {1'b0, start_ff} + {1'b0, rounded_ff};
   assign overflow  = end_sum[33] | end_sum[32];
   assign walk_done = !cur_ff.link_valid || (steps_ff == STEP_W'(TABLE_ENTRIES));
   assign match     = (cur_ff.start == addr_ff);

   assign rsp_valid_in =
      ((state_ff == S_IDLE) && start && (req.action == ACT_FREE) && !nonempty_ff) ||
      ((state_ff == S_SCAN) && used_ff[scan_ff] &&
       (scan_ff == SLOT_W'(TABLE_ENTRIES - 1))) ||
      ((state_ff == S_CHECK) && (overflow || !nonempty_ff)) ||
      (state_ff == S_AWLINK) ||
      ((state_ff == S_FSTEP) && (match || walk_done));

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = cur_ff;
      ram_raddr = ((state_ff == S_IDLE) || (state_ff == S_SCAN)) ? head_ff : cur_ff.link;
      case (state_ff)
         S_CHECK: begin
            ram_we               = !overflow;
            ram_waddr            = slot_ff;
            ram_wdata.start      = start_ff[31:0];
            ram_wdata.span       = rounded_ff[31:0];
            ram_wdata.link       = nonempty_ff ? cur_ff.link : '0;
            ram_wdata.link_valid = nonempty_ff & cur_ff.link_valid;
         end
         S_AWLINK: begin
            ram_we               = 1'b1;
            ram_waddr            = p_ff;
            ram_wdata            = cur_ff;
            ram_wdata.link       = slot_ff;
            ram_wdata.link_valid = 1'b1;
         end
         S_FSTEP: begin
            ram_we               = match && has_prev_ff;
            ram_waddr            = prevp_ff;
            ram_wdata            = prev_ff;
            ram_wdata.link       = cur_ff.link;
            ram_wdata.link_valid = cur_ff.link_valid;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   ffra_ram #(
      .DEPTH(TABLE_ENTRIES),
      .WIDTH($bits(entry_type))
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= BASE_RESET;
         used_ff      <= '0;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            base_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rounded_ff  <= {round_sum[32:PAGE_W], PAGE_W'(0)};
                  addr_ff     <= req.free_address;
                  scan_ff     <= '0;
                  p_ff        <= head_ff;
                  steps_ff    <= '0;
                  has_prev_ff <= 1'b0;
                  if (req.action == ACT_ALLOC) begin
                     state_ff <= S_SCAN;
                  end else if (!nonempty_ff) begin
                     rsp_ff <= '{status: ST_NOT_FOUND, region_address: '0,
                                 live_regions: 8'(total_ff)};
                  end else begin
                     state_ff <= S_FWAIT;
                  end
               end
            end
            S_SCAN: begin
               if (!used_ff[scan_ff]) begin
                  slot_ff <= scan_ff;
                  if (!nonempty_ff) begin
                     start_ff <= {1'b0, base_ff};
                     state_ff <= S_CHECK;
                  end else begin
                     state_ff <= S_AHEAD;
                  end
               end else if (scan_ff == SLOT_W'(TABLE_ENTRIES - 1)) begin
                  rsp_ff <= '{status: ST_FULL, region_address: '0,
                              live_regions: 8'(total_ff)};
                  state_ff <= S_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_AHEAD: begin
               cur_ff     <= ram_rdata;
               cur_end_ff <= {1'b0, ram_rdata.start} + {1'b0, ram_rdata.span};
               state_ff   <= S_ASTEP;
            end
            S_ASTEP: begin
               if (walk_done) begin
                  start_ff <= cur_end_ff;
                  state_ff <= S_CHECK;
               end else begin
                  state_ff <= S_ANEXT;
               end
            end
            S_ANEXT: begin
               if (fits) begin
                  start_ff <= cur_end_ff;
                  state_ff <= S_CHECK;
               end else begin
                  p_ff       <= cur_ff.link;
                  cur_ff     <= ram_rdata;
                  cur_end_ff <= {1'b0, ram_rdata.start} + {1'b0, ram_rdata.span};
                  steps_ff   <= steps_ff + 1'b1;
                  state_ff   <= S_ASTEP;
               end
            end
            S_CHECK: begin
               if (overflow) begin
                  rsp_ff <= '{status: ST_OVERFLOW, region_address: '0,
                              live_regions: 8'(total_ff)};
                  state_ff <= S_IDLE;
               end else if (!nonempty_ff) begin
                  used_ff[slot_ff] <= 1'b1;
                  head_ff          <= slot_ff;
                  nonempty_ff      <= 1'b1;
                  total_ff         <= total_ff + 1'b1;
                  rsp_ff <= '{status: ST_OK, region_address: start_ff[31:0],
                              live_regions: 8'(total_ff + 1'b1)};
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_AWLINK;
               end
            end
            S_AWLINK: begin
               used_ff[slot_ff] <= 1'b1;
               total_ff         <= total_ff + 1'b1;
               rsp_ff <= '{status: ST_OK, region_address: start_ff[31:0],
                           live_regions: 8'(total_ff + 1'b1)};
               state_ff <= S_IDLE;
            end
            S_FWAIT: begin
               cur_ff   <= ram_rdata;
               state_ff <= S_FSTEP;
            end
            S_FSTEP: begin
               if (match) begin
                  if (!has_prev_ff) begin
                     head_ff     <= cur_ff.link;
                     nonempty_ff <= cur_ff.link_valid;
                  end
                  used_ff[p_ff] <= 1'b0;
                  if (total_ff != '0) begin
                     total_ff <= total_ff - 1'b1;
                     rsp_ff <= '{status: ST_OK, region_address: '0,
                                 live_regions: 8'(total_ff - 1'b1)};
                  end else begin
                     rsp_ff <= '{status: ST_OK, region_address: '0,
                                 live_regions: 8'(total_ff)};
                  end
                  state_ff <= S_IDLE;
               end else if (walk_done) begin
                  rsp_ff <= '{status: ST_NOT_FOUND, region_address: '0,
                              live_regions: 8'(total_ff)};
                  state_ff <= S_IDLE;
               end else begin
                  prev_ff     <= cur_ff;
                  prevp_ff    <= p_ff;
                  has_prev_ff <= 1'b1;
                  p_ff        <= cur_ff.link;
                  steps_ff    <= steps_ff + 1'b1;
                  state_ff    <= S_FWAIT;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
